// ===== src/bmbd_pkg.sv =====
// ============================================================================
// Banked memory bus decoder package
// Shared sizes, address map constants, route and target codes, and the
// decoded command that travels from the front end to the back end.
// ============================================================================
package bmbd_pkg;

    localparam int VIDEO_BANKS = 2;
    localparam int WORK_BANKS  = 8;

    localparam int VBANK_SIZE = 'h2000;
    localparam int WBANK_SIZE = 'h1000;
    localparam int VOFF_W     = $clog2(VBANK_SIZE);
    localparam int WOFF_W     = $clog2(WBANK_SIZE);

    localparam int VRAM_DEPTH = VIDEO_BANKS * VBANK_SIZE;
    localparam int VRAM_AW    = $clog2(VRAM_DEPTH);
    localparam int WRAM_DEPTH = WORK_BANKS * WBANK_SIZE;
    localparam int WRAM_AW    = $clog2(WRAM_DEPTH);
    localparam int OAM_DEPTH  = 160;
    localparam int OAM_AW     = $clog2(OAM_DEPTH);
    localparam int IO_DEPTH   = 128;
    localparam int IO_AW      = $clog2(IO_DEPTH);
    localparam int HRAM_DEPTH = 127;
    localparam int HRAM_AW    = $clog2(HRAM_DEPTH);
    localparam int IDX_W      = (VRAM_AW > WRAM_AW) ? VRAM_AW : WRAM_AW;

    localparam int QUEUE_DEPTH = 2;

    // Address map boundaries.
    localparam logic [15:0] A_VRAM   = 16'h8000;
    localparam logic [15:0] A_XRAM   = 16'hA000;
    localparam logic [15:0] A_WRAM   = 16'hC000;
    localparam logic [15:0] A_OAM    = 16'hFE00;
    localparam logic [15:0] A_UNUSED = 16'hFEA0;
    localparam logic [15:0] A_IO     = 16'hFF00;
    localparam logic [15:0] A_HRAM   = 16'hFF80;
    localparam logic [15:0] A_IE     = 16'hFFFF;

    // IO register addresses.
    localparam logic [15:0] A_JOYP    = 16'hFF00;
    localparam logic [15:0] A_DIV     = 16'hFF04;
    localparam logic [15:0] A_AUD_LO  = 16'hFF10;
    localparam logic [15:0] A_AUD_HI  = 16'hFF3F;
    localparam logic [15:0] A_LY      = 16'hFF44;
    localparam logic [15:0] A_DMA     = 16'hFF46;
    localparam logic [15:0] A_VBK     = 16'hFF4F;
    localparam logic [15:0] A_HDMA    = 16'hFF55;
    localparam logic [15:0] A_PAL_LO  = 16'hFF68;
    localparam logic [15:0] A_PAL_HI  = 16'hFF6B;
    localparam logic [15:0] A_SVBK    = 16'hFF70;

    typedef enum logic [2:0] {
        RT_LOCAL   = 3'd0,
        RT_CART    = 3'd1,
        RT_AUDIO   = 3'd2,
        RT_PALETTE = 3'd3,
        RT_OAMDMA  = 3'd4,
        RT_HDMA    = 3'd5
    } t_route;

    typedef enum logic [2:0] {
        T_NONE = 3'd0,
        T_VRAM = 3'd1,
        T_WRAM = 3'd2,
        T_OAM  = 3'd3,
        T_IO   = 3'd4,
        T_HRAM = 3'd5,
        T_IE   = 3'd6
    } t_target;

    typedef struct packed {
        t_target            target;
        logic               wr;
        logic [IDX_W-1:0]   idx;
        logic [7:0]         data;
        t_route             route;
        logic [15:0]        fwd_addr;
        logic [7:0]         fwd_data;
    } t_cmd;

    // Bank actually used by the switchable work RAM window. The raw value is
    // reduced modulo the bank count, and bank zero maps to bank one.
    function automatic logic [2:0] work_bank_sel(input logic [2:0] raw);
        logic [3:0] b;
        b = {1'b0, raw};
        for (int k = 0; k < 4; k++) begin
            if (b >= 4'(WORK_BANKS)) begin
                b = b - 4'(WORK_BANKS);
            end
        end
        if (b == 4'd0) begin
            b = 4'd1;
        end
        return b[2:0];
    endfunction

    function automatic logic video_bank_sel(input logic raw);
        return (VIDEO_BANKS > 1) ? raw : 1'b0;
    endfunction

endpackage

// ===== src/bmbd_ifs.sv =====
// ============================================================================
// Banked memory bus decoder channels
// Valid/ready channels for bus access beats and result beats.
// ============================================================================
interface bmbd_req_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  joypad_state;

    modport source (output valid, output operation, output address,
                    output write_data, output joypad_state, input ready);
    modport sink   (input valid, input operation, input address,
                    input write_data, input joypad_state, output ready);
endinterface

interface bmbd_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  read_data;
    logic [2:0]  route;
    logic [15:0] forward_address;
    logic [7:0]  forward_data;

    modport source (output valid, output read_data, output route,
                    output forward_address, output forward_data, input ready);
    modport sink   (input valid, input read_data, input route,
                    input forward_address, input forward_data, output ready);
endinterface

// ===== src/bmbd_front.sv =====
// ============================================================================
// Banked memory bus decoder front end
// Accepts access beats, decodes the address map and the bank registers,
// and pushes one decoded command per beat into the queue.
// ============================================================================
module bmbd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bmbd_req_if.sink      i_req,
    input  logic          i_full,
    output logic          o_push,
    output bmbd_pkg::t_cmd o_cmd
);
    import bmbd_pkg::*;

    logic [15:0] a;
    logic        wr;
    logic [7:0]  v;
    logic        r_vbank;
    logic        n_vbank;
    logic [2:0]  r_wbank;
    logic [2:0]  n_wbank;
    t_cmd        c;
    logic        is_audio;
    logic [2:0]  wbank_use;

    assign a  = i_req.address;
    assign wr = i_req.operation;
    assign v  = i_req.write_data;

    assign is_audio  = (a >= A_AUD_LO) && (a <= A_AUD_HI);
    assign wbank_use = a[WOFF_W] ? r_wbank : 3'd0;

    always_comb begin
        c          = '0;
        c.target   = T_NONE;
        c.route    = RT_LOCAL;
        c.wr       = wr;
        c.data     = v;
        n_vbank    = r_vbank;
        n_wbank    = r_wbank;
        priority if (a < A_VRAM || (a >= A_XRAM && a < A_WRAM)) begin
            c.route = RT_CART;
        end else if (a < A_XRAM) begin
            c.target = T_VRAM;
            c.idx    = IDX_W'({r_vbank, a[VOFF_W-1:0]});
        end else if (a < A_OAM) begin
            // The echo region shares the offset bits, so both windows map alike.
            c.target = T_WRAM;
            c.idx    = IDX_W'({wbank_use, a[WOFF_W-1:0]});
        end else if (a < A_UNUSED) begin
            c.target = T_OAM;
            c.idx    = IDX_W'(a[OAM_AW-1:0]);
        end else if (a < A_IO) begin
            c.target = T_NONE;
        end else if (a < A_HRAM) begin
            c.idx = IDX_W'(a[IO_AW-1:0]);
            if (!wr) begin
                if (is_audio) begin
                    c.route = RT_AUDIO;
                end else begin
                    c.target = T_IO;
                end
            end else begin
                c.target = T_IO;
                priority if (a == A_DIV || a == A_LY) begin
                    c.data = 8'h00;
                end else if (a == A_DMA) begin
                    c.route = RT_OAMDMA;
                end else if (a == A_JOYP) begin
                    c.data = i_req.joypad_state;
                end else if (is_audio) begin
                    c.route = RT_AUDIO;
                end else if (a == A_VBK) begin
                    n_vbank = video_bank_sel(v[0]);
                end else if (a == A_SVBK) begin
                    n_wbank = work_bank_sel(v[2:0]);
                end else if (a >= A_PAL_LO && a <= A_PAL_HI) begin
                    c.route = RT_PALETTE;
                end else if (a == A_HDMA) begin
                    c.route = RT_HDMA;
                end else begin
                    c.data = v;
                end
            end
        end else if (a < A_IE) begin
            c.target = T_HRAM;
            c.idx    = IDX_W'(a[HRAM_AW-1:0]);
        end else begin
            c.target = T_IE;
        end
        if (c.route != RT_LOCAL) begin
            c.fwd_addr = a;
            c.fwd_data = wr ? v : 8'h00;
        end
    end

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full;
    assign o_cmd       = c;

    // Bank registers live here so that later beats decode with the bank that
    // earlier beats selected, in bus order.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vbank <= 1'b0;
            r_wbank <= work_bank_sel(3'd0);
        end else if (o_push) begin
            r_vbank <= n_vbank;
            r_wbank <= n_wbank;
        end
    end

endmodule

// ===== src/bmbd_fifo.sv =====
// ============================================================================
// Banked memory bus decoder command queue
// Short queue of decoded commands between the front and back ends.
// ============================================================================
module bmbd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bmbd_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_avail,
    output bmbd_pkg::t_cmd o_cmd
);
    import bmbd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_avail = (r_count != '0);
    assign o_cmd   = r_slot[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= ptr_inc(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= ptr_inc(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== src/bmbd_back.sv =====
// ============================================================================
// Banked memory bus decoder back end
// Carries out decoded commands on the local stores and registers results.
// ============================================================================
module bmbd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_avail,
    input  bmbd_pkg::t_cmd i_cmd,
    output logic           o_pop,
    bmbd_rsp_if.source     o_rsp
);
    import bmbd_pkg::*;

    typedef struct packed {
        logic [7:0]  read_data;
        t_route      route;
        logic [15:0] fwd_addr;
        logic [7:0]  fwd_data;
    } t_rsp;

    logic [7:0] r_vram [VRAM_DEPTH];
    logic [7:0] r_wram [WRAM_DEPTH];
    logic [7:0] r_oam  [OAM_DEPTH];
    logic [7:0] r_io   [IO_DEPTH];
    logic [7:0] r_hram [HRAM_DEPTH];
    logic [7:0] r_ie;

    logic [7:0] r_vram_rd;
    logic [7:0] r_wram_rd;
    logic [7:0] r_oam_rd;
    logic [7:0] r_io_rd;
    logic [7:0] r_hram_rd;
    logic [7:0] r_ie_rd;

    t_cmd r_s1;
    logic r_s1_v;
    t_rsp r_out;
    t_rsp n_out;
    logic r_out_v;
    logic adv;
    logic [7:0] n_rd;

    assign adv   = r_s1_v && (!r_out_v || o_rsp.ready);
    assign o_pop = i_avail && (!r_s1_v || adv);

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.target == T_VRAM) begin
            if (i_cmd.wr) begin
                r_vram[i_cmd.idx[VRAM_AW-1:0]] <= i_cmd.data;
            end else begin
                r_vram_rd <= r_vram[i_cmd.idx[VRAM_AW-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.target == T_WRAM) begin
            if (i_cmd.wr) begin
                r_wram[i_cmd.idx[WRAM_AW-1:0]] <= i_cmd.data;
            end else begin
                r_wram_rd <= r_wram[i_cmd.idx[WRAM_AW-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.target == T_OAM) begin
            if (i_cmd.wr) begin
                r_oam[i_cmd.idx[OAM_AW-1:0]] <= i_cmd.data;
            end else begin
                r_oam_rd <= r_oam[i_cmd.idx[OAM_AW-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.target == T_IO) begin
            if (i_cmd.wr) begin
                r_io[i_cmd.idx[IO_AW-1:0]] <= i_cmd.data;
            end else begin
                r_io_rd <= r_io[i_cmd.idx[IO_AW-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.target == T_HRAM) begin
            if (i_cmd.wr) begin
                r_hram[i_cmd.idx[HRAM_AW-1:0]] <= i_cmd.data;
            end else begin
                r_hram_rd <= r_hram[i_cmd.idx[HRAM_AW-1:0]];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ie <= 8'h00;
        end else if (o_pop && i_cmd.target == T_IE && i_cmd.wr) begin
            r_ie <= i_cmd.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_cmd.target == T_IE && !i_cmd.wr) begin
            r_ie_rd <= r_ie;
        end
    end

    always_comb begin
        unique case (r_s1.target)
            T_VRAM:  n_rd = r_vram_rd;
            T_WRAM:  n_rd = r_wram_rd;
            T_OAM:   n_rd = r_oam_rd;
            T_IO:    n_rd = r_io_rd;
            T_HRAM:  n_rd = r_hram_rd;
            T_IE:    n_rd = r_ie_rd;
            T_NONE:  n_rd = 8'h00;
            default: n_rd = 8'h00;
        endcase
        n_out.read_data = r_s1.wr ? 8'h00 : n_rd;
        n_out.route     = r_s1.route;
        n_out.fwd_addr  = r_s1.fwd_addr;
        n_out.fwd_data  = r_s1.fwd_data;
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1 <= i_cmd;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (o_pop) begin
                r_s1_v <= 1'b1;
            end else if (adv) begin
                r_s1_v <= 1'b0;
            end
            if (adv) begin
                r_out_v <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    assign o_rsp.valid           = r_out_v;
    assign o_rsp.read_data       = r_out.read_data;
    assign o_rsp.route           = r_out.route;
    assign o_rsp.forward_address = r_out.fwd_addr;
    assign o_rsp.forward_data    = r_out.fwd_data;

`ifndef SYNTHESIS
    // A forwarded beat never carries local read data.
    a_fwd_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out.route != RT_LOCAL |-> r_out.read_data == 8'h00)
        else $error("forwarded beat carries read data");

    // A local beat forwards nothing.
    a_local_no_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && r_out.route == RT_LOCAL |->
            r_out.fwd_addr == 16'h0000 && r_out.fwd_data == 8'h00)
        else $error("local beat carries forward fields");

    // A command held in the access stage is not lost while the output stalls.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && !adv |=> r_s1_v && $stable(r_s1))
        else $error("access stage dropped a command");

    // The queue is only popped when it holds a command.
    a_pop_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_avail)
        else $error("pop from empty queue");
`endif

endmodule

// ===== src/banked_memory_bus_decoder_unit.sv =====
// ============================================================================
// Banked memory bus decoder
// Handheld console memory map: local stores, bank registers and forwarding.
// ============================================================================
// Each access beat on i_req (read or write, 16-bit address, data byte and
// joypad byte) produces exactly one result beat on o_rsp, in order. Video RAM
// (8000-9FFF, banked by VBK), work RAM (C000-DFFF with a switchable upper
// bank chosen by SVBK, mirrored at E000-FDFF), the sprite table, the IO
// bytes, high RAM and the interrupt-enable byte are served locally; cartridge
// space, audio ports, palette writes and the DMA and HDMA start writes come
// back with a nonzero route plus the address and write byte for the unit
// that handles them. Writes to DIV and LY store zero and a write to JOYP
// stores the joypad byte. The block sustains one access per cycle while the
// output is not stalled; an accepted beat passes through the two-entry
// command queue, then the access stage where the single-port store is read
// into a register, and then the output register that drives o_rsp.
// Accesses are accepted while the queue has room, so a stalled output fills
// the queue, the access stage and the output register within four beats and
// then holds i_req off. The local stores start undefined after reset and
// need no clearing pass; besides the queue pointers and the valid flags,
// only the bank registers and the interrupt-enable byte are reset.
// ============================================================================
module banked_memory_bus_decoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bmbd_req_if.sink   i_req,
    bmbd_rsp_if.source o_rsp
);
    import bmbd_pkg::*;

    // Decoded command from the front end and the queue head for the back end.
    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic full;
    logic avail;

    // The front end classifies each beat and tracks the bank registers.
    bmbd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // The queue decouples acceptance from the store accesses.
    bmbd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_avail (avail),
        .o_cmd   (head_cmd)
    );

    // The back end owns the stores and the result register.
    bmbd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (avail),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

endmodule
